// File: src/cell_balance_discharge_select_top_macros.svh
// Assertion macros for the cell balance discharge select block.
// Used by the checker module; depends on nothing else.
`ifndef CELL_BALANCE_DISCHARGE_SELECT_TOP_MACROS_SVH
`define CELL_BALANCE_DISCHARGE_SELECT_TOP_MACROS_SVH

// Implication check, disabled while reset is asserted.
`define CBDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbds implication check failed");

// Invariant check, disabled while reset is asserted.
`define CBDS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("cbds invariant check failed");

`endif

// File: src/cbds_pkg.sv
// Shared types and constants for the cell balance discharge select block.
// Used by every module of the block; depends on nothing.
package cbds_pkg;

    localparam int CELLS  = 6;
    localparam int MV_W   = 13;
    localparam int MOD_W  = 4;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = $clog2(CELLS);
    // Signed excess wide enough for a cell voltage and a full threshold.
    localparam int DIFF_W = CFG_W + 2;
    // One stage per cell, one walk step per stage.
    localparam int LATENCY = CELLS;

    // Configuration register indexes.
    localparam int REG_IDX_W = 4;
    localparam logic [REG_IDX_W-1:0] REG_BALANCE_THRESHOLD = 4'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_EXCESS        = 4'd1;

    typedef struct packed {
        logic [MV_W-1:0]  cell_mv_0;
        logic [MV_W-1:0]  cell_mv_1;
        logic [MV_W-1:0]  cell_mv_2;
        logic [MV_W-1:0]  cell_mv_3;
        logic [MV_W-1:0]  cell_mv_4;
        logic [MV_W-1:0]  cell_mv_5;
        logic [MV_W-1:0]  pack_min_mv;
        logic [MOD_W-1:0] module_in;
    } t_in_item;

    typedef struct packed {
        logic [CELLS-1:0] discharge_mask;
        logic [MOD_W-1:0] module_out;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] balance_threshold;
        logic [CFG_W-1:0] min_excess_mv;
    } t_cfg;

    // State of one item's walk as it moves down the chain.
    typedef struct packed {
        logic [CELLS-1:0][MV_W-1:0] mv;
        logic [MV_W-1:0]            pack_min_mv;
        logic [MOD_W-1:0]           module_id;
        logic [CELLS-1:0]           visited;
        logic [CELLS-1:0]           mask;
        logic                       active;
    } t_walk;

endpackage

// File: src/cbds_cell.sv
// One step of the discharge walk: picks the highest unvisited cell and decides it.
// Depends on cbds_pkg.
module cbds_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cbds_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  cbds_pkg::t_walk i_walk,
    output logic            o_valid,
    output cbds_pkg::t_walk o_walk
);

    logic                                r_valid;
    cbds_pkg::t_walk                     r_walk;
    cbds_pkg::t_walk                     n_walk;
    logic [cbds_pkg::MV_W-1:0]           best_val;
    logic [cbds_pkg::IDX_W-1:0]          best_idx;
    logic [cbds_pkg::CELLS-1:0]          neigh;
    logic signed [cbds_pkg::DIFF_W-1:0]  excess;
    logic                                take;
    logic                                diff_ok;

    // Highest unvisited nonzero cell; strict compare keeps the lower index on ties.
    always_comb begin
        best_val = '0;
        best_idx = '0;
        for (int j = 0; j < cbds_pkg::CELLS; j++) begin
            if (!i_walk.visited[j] && (i_walk.mv[j] > best_val)) begin
                best_val = i_walk.mv[j];
                best_idx = cbds_pkg::IDX_W'(j);
            end
        end
    end

    // Stop conditions, neighbor check and signed excess over the pack minimum.
    assign take    = i_walk.active && (best_val != '0) &&
                     (cbds_pkg::CFG_W'(best_val) >= i_cfg.balance_threshold);
    assign neigh   = (i_walk.mask << 1) | (i_walk.mask >> 1);
    assign excess  = $signed(cbds_pkg::DIFF_W'(best_val)) -
                     $signed(cbds_pkg::DIFF_W'(i_walk.pack_min_mv));
    assign diff_ok = excess >= $signed(cbds_pkg::DIFF_W'(i_cfg.min_excess_mv));

    // Next walk state handed to the following cell.
    always_comb begin
        n_walk = i_walk;
        if (take) begin
            n_walk.visited[best_idx] = 1'b1;
            if (!neigh[best_idx] && diff_ok) begin
                n_walk.mask[best_idx] = 1'b1;
            end
        end else begin
            n_walk.active = 1'b0;
        end
    end

    // Valid bit is reset; the walk payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk <= n_walk;
    end

    assign o_valid = r_valid;
    assign o_walk  = r_walk;

endmodule

// File: src/cell_balance_discharge_select_top.sv
// Top level of the cell balance discharge select block: config registers and cell chain.
// Depends on cbds_pkg and cbds_cell.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  item in  | i_start, o_busy (low)     | i_item (cbds_pkg::t_in_item)
//  config   | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
//  result   | o_result_valid (strobe)   | o_result (cbds_pkg::t_out_item)
//
// An item can be accepted every cycle; o_busy is never raised.
// Each result passes through the chain of registered cells, one walk step per cell.
// Synchronous active-low reset clears the stage valid bits and both thresholds.
// The result is a one-cycle strobe; the receiver cannot stall it.
module cell_balance_discharge_select_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  cbds_pkg::t_in_item                 i_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cbds_pkg::REG_IDX_W-1:0]     i_cfg_index,
    input  logic [cbds_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                               o_result_valid,
    output cbds_pkg::t_out_item                o_result
);

    cbds_pkg::t_cfg  r_cfg;
    cbds_pkg::t_walk walk  [0:cbds_pkg::CELLS];
    logic            valid [0:cbds_pkg::CELLS];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Threshold registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cbds_pkg::REG_BALANCE_THRESHOLD: begin
                    r_cfg.balance_threshold <= i_cfg_data;
                end
                cbds_pkg::REG_MIN_EXCESS: begin
                    r_cfg.min_excess_mv <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Initial walk state for an accepted item.
    always_comb begin
        walk[0].mv[0]       = i_item.cell_mv_0;
        walk[0].mv[1]       = i_item.cell_mv_1;
        walk[0].mv[2]       = i_item.cell_mv_2;
        walk[0].mv[3]       = i_item.cell_mv_3;
        walk[0].mv[4]       = i_item.cell_mv_4;
        walk[0].mv[5]       = i_item.cell_mv_5;
        walk[0].pack_min_mv = i_item.pack_min_mv;
        walk[0].module_id   = i_item.module_in;
        walk[0].visited     = '0;
        walk[0].mask        = '0;
        walk[0].active      = 1'b1;
    end
    assign valid[0] = i_start && !o_busy;

    // Chain of identical cells, one walk step each.
    for (genvar k = 0; k < cbds_pkg::CELLS; k++) begin : g_chain
        cbds_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_valid (valid[k]),
            .i_walk  (walk[k]),
            .o_valid (valid[k+1]),
            .o_walk  (walk[k+1])
        );
    end

    // The last cell's registers drive the result directly.
    assign o_result_valid            = valid[cbds_pkg::CELLS];
    assign o_result.discharge_mask   = walk[cbds_pkg::CELLS].mask;
    assign o_result.module_out       = walk[cbds_pkg::CELLS].module_id;

endmodule

// File: src/cbds_checker.sv
// Port-level checks for the cell balance discharge select block, bound to the top level.
// Depends on cbds_pkg and cell_balance_discharge_select_top_macros.svh.
`include "cell_balance_discharge_select_top_macros.svh"

module cbds_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_start,
    input logic                           o_busy,
    input cbds_pkg::t_in_item             i_item,
    input logic                           o_result_valid,
    input cbds_pkg::t_out_item            o_result
);

    logic [cbds_pkg::LATENCY-1:0] r_acc_hist;

    // History of accepted items; reset drops items in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_hist <= '0;
        end else begin
            r_acc_hist <= {r_acc_hist[cbds_pkg::LATENCY-2:0], i_start && !o_busy};
        end
    end

    // Every accepted item yields exactly one result, matched against the acceptance history.
    `CBDS_ASSERT_IMPL(a_result_follows, i_clk, i_rst_n, r_acc_hist[cbds_pkg::LATENCY-1], o_result_valid)
    `CBDS_ASSERT_ALWAYS(a_no_spurious, i_clk, i_rst_n, !o_result_valid || r_acc_hist[cbds_pkg::LATENCY-1])

    // The module number comes back with its own item.
    `CBDS_ASSERT_IMPL(a_module_echo, i_clk, i_rst_n, o_result_valid, o_result.module_out == $past(i_item.module_in, cbds_pkg::LATENCY))

    // Adjacent cells are never discharged together.
    `CBDS_ASSERT_IMPL(a_no_adjacent, i_clk, i_rst_n, o_result_valid, (o_result.discharge_mask & (o_result.discharge_mask >> 1)) == '0)

endmodule

bind cell_balance_discharge_select_top cbds_checker u_cbds_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .i_item         (i_item),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

// File: tb/sv/cell_balance_discharge_select_checker.sv
// Checker for the cell balance discharge select block: watches the item, config and
// result channels, predicts each discharge mask and compares it with the block's result.
// Depends on cbds_pkg.
module cell_balance_discharge_select_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  cbds_pkg::t_in_item             i_item,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [cbds_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [cbds_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_result_valid,
    input  cbds_pkg::t_out_item            i_result,
    output int                             o_fail_count,
    output int                             o_outstanding
);

    // Masks still owed by the block, oldest first.
    cbds_pkg::t_out_item        owed_masks[$];
    logic [cbds_pkg::CFG_W-1:0] balance_mv;
    logic [cbds_pkg::CFG_W-1:0] excess_mv;
    int                         fail_total = 0;
    int                         owed_total = 0;

    assign o_fail_count  = fail_total;
    assign o_outstanding = owed_total;

    // Walk the cells from the highest voltage down and pick the ones to discharge.
    function automatic logic [cbds_pkg::CELLS-1:0] pick_discharge(
        input cbds_pkg::t_in_item         scan,
        input logic [cbds_pkg::CFG_W-1:0] stop_mv,
        input logic [cbds_pkg::CFG_W-1:0] min_excess
    );
        logic [cbds_pkg::CELLS-1:0][cbds_pkg::MV_W-1:0] mv;
        logic [cbds_pkg::CELLS-1:0]                     walked;
        logic [cbds_pkg::CELLS-1:0]                     mask;
        logic [cbds_pkg::CELLS-1:0]                     near;
        int                                             top_idx;
        int                                             top_mv;
        bit                                             halted;
        mv = {scan.cell_mv_5, scan.cell_mv_4, scan.cell_mv_3,
              scan.cell_mv_2, scan.cell_mv_1, scan.cell_mv_0};
        walked = '0;
        mask   = '0;
        halted = 1'b0;
        for (int step = 0; step < cbds_pkg::CELLS; step++) begin
            if (!halted) begin
                // Strict compare: ties go to the lower index, zero-volt cells are never picked.
                top_idx = -1;
                top_mv  = 0;
                for (int c = 0; c < cbds_pkg::CELLS; c++) begin
                    if (!walked[c] && int'(mv[c]) > top_mv) begin
                        top_idx = c;
                        top_mv  = int'(mv[c]);
                    end
                end
                if (top_idx < 0 || top_mv < int'(stop_mv)) begin
                    halted = 1'b1;
                end else begin
                    walked[top_idx] = 1'b1;
                    near = (mask << 1) | (mask >> 1);
                    if (!near[top_idx] &&
                        top_mv - int'(scan.pack_min_mv) >= int'(min_excess)) begin
                        mask[top_idx] = 1'b1;
                    end
                end
            end
        end
        return mask;
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        if (fail_total < 10) begin
            $display("mismatch on %0s: expected 0x%0h, got 0x%0h", what, want, got);
        end
        fail_total++;
    endtask

    // Compare results first, then record the new item and any register write.
    always @(posedge i_clk) begin
        cbds_pkg::t_out_item want;
        if (!i_rst_n) begin
            owed_masks.delete();
            owed_total = 0;
            balance_mv = '0;
            excess_mv  = '0;
        end else begin
            if (i_result_valid) begin
                if (owed_masks.size() == 0) begin
                    note_mismatch("unrequested result", 0, int'(i_result));
                end else begin
                    want = owed_masks.pop_front();
                    if (i_result.discharge_mask !== want.discharge_mask) begin
                        note_mismatch("discharge_mask", int'(want.discharge_mask),
                                      int'(i_result.discharge_mask));
                    end
                    if (i_result.module_out !== want.module_out) begin
                        note_mismatch("module_out", int'(want.module_out),
                                      int'(i_result.module_out));
                    end
                end
            end
            if (i_start && !i_busy) begin
                want.discharge_mask = pick_discharge(i_item, balance_mv, excess_mv);
                want.module_out     = i_item.module_in;
                owed_masks.push_back(want);
            end
            owed_total = owed_masks.size();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    cbds_pkg::REG_BALANCE_THRESHOLD: begin
                        balance_mv = i_cfg_data;
                    end
                    cbds_pkg::REG_MIN_EXCESS: begin
                        excess_mv = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// File: tb/sv/cell_balance_discharge_select_top_tb.sv
// Testbench top for the cell balance discharge select block: drives module scans and
// threshold writes, and gives the verdict. Depends on cbds_pkg, the block and its checker.
module cell_balance_discharge_select_top_tb;

    localparam int MV_MAX      = (1 << cbds_pkg::MV_W) - 1;
    localparam int CYCLE_LIMIT = 400000;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_start     = 1'b0;
    cbds_pkg::t_in_item             i_item      = '0;
    logic                           i_cfg_valid = 1'b0;
    logic [cbds_pkg::REG_IDX_W-1:0] i_cfg_index = '0;
    logic [cbds_pkg::CFG_W-1:0]     i_cfg_data  = '0;
    logic                           o_busy;
    logic                           o_cfg_ready;
    logic                           o_result_valid;
    cbds_pkg::t_out_item            o_result;
    int                             fail_count;
    int                             owed_count;
    int                             cycle_count = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    cell_balance_discharge_select_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_item         (i_item),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    cell_balance_discharge_select_checker u_mask_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_item         (i_item),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .o_fail_count   (fail_count),
        .o_outstanding  (owed_count)
    );

    function automatic cbds_pkg::t_in_item build_scan(input int c0, input int c1,
                                                      input int c2, input int c3,
                                                      input int c4, input int c5,
                                                      input int pmin, input int mod_id);
        cbds_pkg::t_in_item scan;
        scan.cell_mv_0   = cbds_pkg::MV_W'(c0);
        scan.cell_mv_1   = cbds_pkg::MV_W'(c1);
        scan.cell_mv_2   = cbds_pkg::MV_W'(c2);
        scan.cell_mv_3   = cbds_pkg::MV_W'(c3);
        scan.cell_mv_4   = cbds_pkg::MV_W'(c4);
        scan.cell_mv_5   = cbds_pkg::MV_W'(c5);
        scan.pack_min_mv = cbds_pkg::MV_W'(pmin);
        scan.module_in   = cbds_pkg::MOD_W'(mod_id);
        return scan;
    endfunction

    // Mostly a realistic module scan clustered above lo_mv, with ties and dead cells;
    // one in ten is raw noise over the full field width.
    function automatic cbds_pkg::t_in_item scan_item(input int lo_mv, input int spread);
        int mv[cbds_pkg::CELLS];
        int pmin;
        int v;
        if ($urandom_range(0, 9) == 0) begin
            foreach (mv[c]) mv[c] = $urandom_range(0, MV_MAX);
            pmin = $urandom_range(0, MV_MAX);
        end else begin
            for (int c = 0; c < cbds_pkg::CELLS; c++) begin
                v = lo_mv + $urandom_range(0, spread);
                if (c > 0 && $urandom_range(0, 5) == 0) v = mv[c-1];
                if ($urandom_range(0, 19) == 0) v = 0;
                mv[c] = (v > MV_MAX) ? MV_MAX : v;
            end
            if ($urandom_range(0, 7) == 0) pmin = lo_mv + $urandom_range(0, spread);
            else pmin = lo_mv - $urandom_range(0, 20);
            if (pmin < 0) pmin = 0;
            if (pmin > MV_MAX) pmin = MV_MAX;
        end
        return build_scan(mv[0], mv[1], mv[2], mv[3], mv[4], mv[5], pmin,
                          $urandom_range(0, 15));
    endfunction

    // Present one item and hold it until the block takes it; start stays high afterward.
    task automatic send_scan(input cbds_pkg::t_in_item scan);
        bit took;
        i_start <= 1'b1;
        i_item  <= scan;
        do begin
            @(negedge i_clk);
            took = !o_busy;
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic cfg_write(input logic [cbds_pkg::REG_IDX_W-1:0] idx, input int data);
        bit took;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= cbds_pkg::CFG_W'(data);
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    // Stop sending and let every owed result come out, then let the chain settle.
    task automatic wait_idle();
        i_start <= 1'b0;
        do @(negedge i_clk); while (owed_count != 0);
        repeat (cbds_pkg::LATENCY + 2) @(posedge i_clk);
    endtask

    // Writes both thresholds, then one write to an unused index that must be ignored.
    task automatic set_thresholds(input int balance_mv, input int excess_mv);
        wait_idle();
        cfg_write(cbds_pkg::REG_BALANCE_THRESHOLD, balance_mv);
        cfg_write(cbds_pkg::REG_MIN_EXCESS, excess_mv);
        cfg_write(cbds_pkg::REG_IDX_W'(cbds_pkg::REG_MIN_EXCESS + $urandom_range(1, 14)),
                  $urandom_range(0, 65535));
        i_cfg_valid <= 1'b0;
    endtask

    // Random scans in bursts with gaps; now and then a full drain.
    task automatic run_scans(input int count, input int lo_mv, input int spread);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < count; n++) begin
            send_scan(scan_item(lo_mv, spread));
            burst_left--;
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                if ($urandom_range(0, 29) == 0) begin
                    wait_idle();
                end else if (gap > 0) begin
                    i_start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    // Run watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int bal;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset thresholds: dead module, all full, all equal, cells under the pack minimum.
        send_scan(build_scan(0, 0, 0, 0, 0, 0, 0, 0));
        send_scan(build_scan(MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX, 0, 15));
        send_scan(build_scan(4000, 4000, 4000, 4000, 4000, 4000, 4000, 3));
        send_scan(build_scan(3000, 3100, 3200, 3300, 3400, 3500, 5000, 7));
        send_scan(build_scan(0, 4000, 3900, 4100, 3800, 0, 3700, 9));
        send_scan(build_scan(0, 0, 0, 1, 0, 0, 0, 12));

        // Walk stops at the balance threshold, excess exactly at and one under the limit.
        set_thresholds(3300, 20);
        send_scan(build_scan(3400, 3250, 3500, 3310, 3299, 3600, 3200, 1));
        send_scan(build_scan(3320, 3319, 3330, 3301, 3340, 3300, 3300, 2));
        send_scan(build_scan(3300, 3299, 3300, 3299, 3300, 3299, 3280, 4));
        send_scan(build_scan(MV_MAX, MV_MAX - 20, MV_MAX, 0, MV_MAX, 1, MV_MAX, 15));
        send_scan(build_scan(4000, 3990, 3980, 3970, 3960, 3950, 3000, 8));
        send_scan(build_scan(3950, 3960, 3970, 3980, 3990, 4000, 3000, 6));
        send_scan(build_scan(3500, 0, 3600, 0, 3700, 0, 3400, 11));
        send_scan(build_scan(3400, 3400, 3400, 3400, 3400, 3400, 3390, 14));

        // Extreme thresholds, then typical balancing settings.
        set_thresholds(0, 65535);
        run_scans(80, 3000, 300);
        set_thresholds(65535, 0);
        run_scans(80, 3000, 300);
        set_thresholds(0, 0);
        run_scans(150, 3000, 200);
        set_thresholds(3600, 30);
        run_scans(300, 3500, 250);
        set_thresholds(3900, 5);
        run_scans(300, 3800, 200);
        for (int p = 0; p < 3; p++) begin
            bal = $urandom_range(3000, 4100);
            set_thresholds(bal, $urandom_range(0, 100));
            run_scans(200, bal - 100, $urandom_range(50, 300));
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
